/* src/msr_pkg.sv */
package msr_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TOL_WIDTH  = 16;
   localparam int CSR_WIDTH  = 32;
   localparam int ADDR_WIDTH = 3;

   localparam int TW  = DATA_WIDTH + 1;
   localparam int DDW = 2 * DATA_WIDTH + 1;
   localparam int DSW = 2 * DATA_WIDTH + 4;
   localparam int RW  = DATA_WIDTH + 3;
   localparam int UW  = (DATA_WIDTH + FRAC_BITS + 3) / 2;
   localparam int SK  = (DATA_WIDTH > UW) ? DATA_WIDTH : UW;
   localparam int DVW = UW + 1;
   localparam int NMW = RW + FRAC_BITS;
   localparam int EW  = NMW + 1;

   localparam logic signed [TW-1:0] ONE_T = TW'(64'd1 << FRAC_BITS);

   typedef enum logic [2:0] {
      ST_COMPLEX = 3'd0,
      ST_ZERO    = 3'd1,
      ST_IDENT   = 3'd2,
      ST_NEGDET  = 3'd3,
      ST_TWO     = 3'd4,
      ST_FOUR    = 3'd5,
      ST_UNDEF   = 3'd6
   } status_type;

   typedef enum logic [0:0] {
      REG_TOLERANCE = 1'b0
   } reg_index_type;

   typedef struct packed {
      status_type                   status;
      logic signed [TW-1:0]         t;
      logic signed [TW-1:0]         d;
      logic signed [DATA_WIDTH-1:0] q;
      logic signed [DATA_WIDTH-1:0] r;
   } fside_type;

   typedef struct packed {
      status_type                   status;
      logic                         ok0;
      logic                         ok1;
      logic signed [RW-1:0]         rad0;
      logic signed [RW-1:0]         rad1;
      logic signed [TW-1:0]         d;
      logic signed [DATA_WIDTH-1:0] q;
      logic signed [DATA_WIDTH-1:0] r;
   } front_type;

   typedef struct packed {
      status_type                   status;
      logic                         root;
      logic                         last;
      logic [1:0]                   num;
      logic signed [RW-1:0]         rad;
      logic signed [TW-1:0]         d;
      logic signed [DATA_WIDTH-1:0] q;
      logic signed [DATA_WIDTH-1:0] r;
   } job_type;

   typedef struct packed {
      status_type status;
      logic       root;
      logic       last;
      logic [1:0] num;
      logic [3:0] neg;
   } meta_type;

   typedef struct packed {
      status_type           status;
      logic                 root;
      logic                 last;
      logic [1:0]           num;
      logic signed [EW-1:0] e0;
      logic signed [EW-1:0] e1;
      logic signed [EW-1:0] e2;
      logic signed [EW-1:0] e3;
   } root_res_type;

   typedef struct packed {
      status_type                   status;
      logic [1:0]                   root_number;
      logic signed [DATA_WIDTH-1:0] r00;
      logic signed [DATA_WIDTH-1:0] r01;
      logic signed [DATA_WIDTH-1:0] r10;
      logic signed [DATA_WIDTH-1:0] r11;
      logic                         saturated;
      logic                         last;
   } result_type;

endpackage

/* src/matrix_square_root_2x2.sv */
// throughput: one result word per cycle unless rsp_ready holds the output; set by the single
// result register and the one-root-a-cycle sqrt and divider pipeline; a matrix gives one
// result word per result (one to four)
// reset: clears all valid bits and sets tolerance to 1
module matrix_square_root_2x2 (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [msr_pkg::DATA_WIDTH-1:0]  req_m00,
   input  logic signed [msr_pkg::DATA_WIDTH-1:0]  req_m01,
   input  logic signed [msr_pkg::DATA_WIDTH-1:0]  req_m10,
   input  logic signed [msr_pkg::DATA_WIDTH-1:0]  req_m11,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [2:0]                             rsp_status,
   output logic [1:0]                             rsp_root_number,
   output logic signed [msr_pkg::DATA_WIDTH-1:0]  rsp_r00,
   output logic signed [msr_pkg::DATA_WIDTH-1:0]  rsp_r01,
   output logic signed [msr_pkg::DATA_WIDTH-1:0]  rsp_r10,
   output logic signed [msr_pkg::DATA_WIDTH-1:0]  rsp_r11,
   output logic                                   rsp_saturated,
   output logic                                   rsp_last,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [msr_pkg::ADDR_WIDTH-1:0]         csr_paddr,
   input  logic [msr_pkg::CSR_WIDTH-1:0]          csr_pwdata,
   output logic [msr_pkg::CSR_WIDTH-1:0]          csr_prdata,
   output logic                                   csr_pready
);
   import msr_pkg::*;

   logic [TOL_WIDTH-1:0] tol_ff;

   logic                 fe, f_valid;
   front_type            f_word;

   logic                 x_valid_ff, x_phase_ff, x_take;
   front_type            x_ff;
   job_type              job_word;
   logic                 root_case;

   logic                 je, r_valid;
   root_res_type         r_word;

   logic                 e_valid_ff, e_phase_ff, fin, o_ld, em_ld;
   root_res_type         e_ff;
   logic [DATA_WIDTH:0]  c0, c1, c2, c3;
   result_type           res_in;

   logic                 rsp_valid_ff;
   result_type           rsp_ff;

   function automatic logic [DATA_WIDTH:0] clamp(input logic signed [EW-1:0] v);
      logic fits;
      fits = (v[EW-1:DATA_WIDTH-1] == '0) || (v[EW-1:DATA_WIDTH-1] == '1);
      if (fits) return {1'b0, v[DATA_WIDTH-1:0]};
      else if (v[EW-1]) return {2'b11, (DATA_WIDTH-1)'(0)};
      else return {2'b10, {(DATA_WIDTH-1){1'b1}}};
   endfunction

   // csr
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TOLERANCE) ? CSR_WIDTH'(tol_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_WIDTH'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_TOLERANCE) begin
         tol_ff <= csr_pwdata[TOL_WIDTH-1:0];
      end
   end

   msr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (fe),
      .in_valid  (req_valid),
      .m00       (req_m00),
      .m01       (req_m01),
      .m10       (req_m10),
      .m11       (req_m11),
      .tol       (tol_ff),
      .out_valid (f_valid),
      .out_word  (f_word)
   );

   // split one matrix into one job per root pair, or one status job if it has no root
   always_comb begin
      root_case        = x_ff.status == ST_TWO || x_ff.status == ST_FOUR;
      job_word.status  = x_ff.status;
      job_word.root    = 1'b0;
      job_word.last    = 1'b1;
      job_word.num     = 2'd0;
      job_word.rad     = x_ff.rad0;
      job_word.d       = x_ff.d;
      job_word.q       = x_ff.q;
      job_word.r       = x_ff.r;
      if (root_case) begin
         if (!x_ff.ok0 && !x_ff.ok1) begin
            job_word.status = ST_UNDEF;
         end else if (x_phase_ff) begin
            job_word.root = 1'b1;
            job_word.num  = 2'd2;
            job_word.rad  = x_ff.rad1;
         end else begin
            job_word.root = 1'b1;
            job_word.rad  = x_ff.ok0 ? x_ff.rad0 : x_ff.rad1;
            job_word.last = !(x_ff.ok0 && x_ff.ok1);
         end
      end
   end

   assign x_take    = f_valid && (!x_valid_ff || (je && job_word.last));
   assign fe        = !f_valid || x_take;
   assign req_ready = fe;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         x_phase_ff <= 1'b0;
      end else if (x_take) begin
         x_valid_ff <= 1'b1;
         x_phase_ff <= 1'b0;
         x_ff       <= f_word;
      end else if (x_valid_ff && je) begin
         if (job_word.last) begin
            x_valid_ff <= 1'b0;
         end else begin
            x_phase_ff <= 1'b1;
         end
      end
   end

   msr_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (je),
      .in_valid  (x_valid_ff),
      .in_word   (job_word),
      .out_valid (r_valid),
      .out_word  (r_word)
   );

   // each root job gives +X then -X
   assign fin   = !e_ff.root || e_phase_ff;
   assign o_ld  = e_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign em_ld = r_valid && (!e_valid_ff || (o_ld && fin));
   assign je    = !r_valid || em_ld;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         e_phase_ff <= 1'b0;
      end else if (em_ld) begin
         e_valid_ff <= 1'b1;
         e_phase_ff <= 1'b0;
         e_ff       <= r_word;
      end else if (o_ld) begin
         if (fin) begin
            e_valid_ff <= 1'b0;
         end else begin
            e_phase_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      c0 = clamp(e_phase_ff ? -e_ff.e0 : e_ff.e0);
      c1 = clamp(e_phase_ff ? -e_ff.e1 : e_ff.e1);
      c2 = clamp(e_phase_ff ? -e_ff.e2 : e_ff.e2);
      c3 = clamp(e_phase_ff ? -e_ff.e3 : e_ff.e3);
      res_in.status = e_ff.status;
      if (e_ff.root) begin
         res_in.root_number = e_ff.num + {1'b0, e_phase_ff};
         res_in.r00         = $signed(c0[DATA_WIDTH-1:0]);
         res_in.r01         = $signed(c1[DATA_WIDTH-1:0]);
         res_in.r10         = $signed(c2[DATA_WIDTH-1:0]);
         res_in.r11         = $signed(c3[DATA_WIDTH-1:0]);
         res_in.saturated   = c0[DATA_WIDTH] | c1[DATA_WIDTH] | c2[DATA_WIDTH] | c3[DATA_WIDTH];
         res_in.last        = e_ff.last && e_phase_ff;
      end else begin
         res_in.root_number = 2'd0;
         res_in.r00         = '0;
         res_in.r01         = '0;
         res_in.r10         = '0;
         res_in.r11         = '0;
         res_in.saturated   = 1'b0;
         res_in.last        = e_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_ld) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= res_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_root_number = rsp_ff.root_number;
   assign rsp_r00         = rsp_ff.r00;
   assign rsp_r01         = rsp_ff.r01;
   assign rsp_r10         = rsp_ff.r10;
   assign rsp_r11         = rsp_ff.r11;
   assign rsp_saturated   = rsp_ff.saturated;
   assign rsp_last        = rsp_ff.last;

   a_second_pair: assert property (@(posedge clock) disable iff (reset)
      x_valid_ff && x_phase_ff |-> x_ff.ok0 && x_ff.ok1 && x_ff.status == ST_FOUR)
      else $error("second root pair issued without two valid radicands");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff && !e_ff.root |-> !e_phase_ff && e_ff.last)
      else $error("status word split into two results");

   a_undef_no_root: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff && e_ff.status == ST_UNDEF |-> !e_ff.root)
      else $error("undefined status carries a root");

   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_TWO && rsp_ff.status != ST_FOUR
      |-> rsp_ff.root_number == 2'd0 && rsp_ff.last && !rsp_ff.saturated)
      else $error("status-only word has root fields set");

endmodule

/* src/msr_isqrt.sv */
module msr_isqrt (
   input  logic                      clock,
   input  logic                      en,
   input  logic [2*msr_pkg::SK-1:0]  rad,
   output logic [msr_pkg::SK-1:0]    root
);
   import msr_pkg::*;

   logic [2*SK-1:0] num_ff [SK];
   logic [SK+1:0]   rem_ff [SK];
   logic [SK-1:0]   res_ff [SK];

   for (genvar i = 0; i < SK; i++) begin : g_step
      logic [2*SK-1:0] num_src;
      logic [SK+1:0]   rem_src;
      logic [SK-1:0]   res_src;
      logic [SK+3:0]   rem_sh;
      logic [SK+3:0]   trial;
      logic            ge;

      if (i == 0) begin : g_first
         assign num_src = rad;
         assign rem_src = '0;
         assign res_src = '0;
      end else begin : g_next
         assign num_src = num_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign res_src = res_ff[i-1];
      end

      assign rem_sh = {rem_src, num_src[2*SK-1 -: 2]};
      assign trial  = (SK+4)'({res_src, 2'b01});
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i] <= num_src << 2;
            rem_ff[i] <= ge ? (SK+2)'(rem_sh - trial) : (SK+2)'(rem_sh);
            res_ff[i] <= {res_src[SK-2:0], ge};
         end
      end
   end

   assign root = res_ff[SK-1];

endmodule

/* src/msr_div.sv */
module msr_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [msr_pkg::NMW-1:0]    num,
   input  logic [msr_pkg::DVW-1:0]    den,
   output logic [msr_pkg::NMW-1:0]    quo
);
   import msr_pkg::*;

   logic [NMW-1:0] num_ff [NMW];
   logic [DVW-1:0] rem_ff [NMW];
   logic [DVW-1:0] den_ff [NMW];

   for (genvar i = 0; i < NMW; i++) begin : g_step
      logic [NMW-1:0] num_src;
      logic [DVW-1:0] rem_src;
      logic [DVW-1:0] den_src;
      logic [DVW:0]   tr;
      logic           ge;

      if (i == 0) begin : g_first
         assign num_src = num;
         assign rem_src = '0;
         assign den_src = den;
      end else begin : g_next
         assign num_src = num_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
      end

      assign tr = {rem_src, num_src[NMW-1]};
      assign ge = tr >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i] <= {num_src[NMW-2:0], ge};
            rem_ff[i] <= ge ? DVW'(tr - {1'b0, den_src}) : DVW'(tr);
            den_ff[i] <= den_src;
         end
      end
   end

   assign quo = num_ff[NMW-1];

endmodule

/* src/msr_front.sv */
module msr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [msr_pkg::DATA_WIDTH-1:0] m00,
   input  logic signed [msr_pkg::DATA_WIDTH-1:0] m01,
   input  logic signed [msr_pkg::DATA_WIDTH-1:0] m10,
   input  logic signed [msr_pkg::DATA_WIDTH-1:0] m11,
   input  logic [msr_pkg::TOL_WIDTH-1:0]       tol,
   output logic                                out_valid,
   output msr_pkg::front_type                  out_word
);
   import msr_pkg::*;

   localparam int FL = SK + 5;

   logic [FL-1:0] vld_ff;

   logic signed [DATA_WIDTH-1:0]   p0_ff, q0_ff, r0_ff, s0_ff;

   logic signed [TW-1:0]           t1_ff, d1_ff;
   logic signed [DATA_WIDTH-1:0]   q1_ff, r1_ff;
   logic signed [2*DATA_WIDTH-1:0] ps1_ff, qr1_ff;
   logic                           zero1_ff, ident1_ff;

   logic signed [TW-1:0]           t2_ff, d2_ff;
   logic signed [DATA_WIDTH-1:0]   q2_ff, r2_ff;
   logic signed [2*TW-1:0]         tt2_ff;
   logic signed [DDW-1:0]          det2_ff;
   logic                           zero2_ff, ident2_ff;

   fside_type                      s3_ff;
   logic [2*SK-1:0]                sqd3_ff;
   fside_type                      sd_ff [SK];
   logic [SK-1:0]                  sroot;
   front_type                      o_ff;

   logic                           zero_in, ident_in;
   logic signed [DSW-1:0]          disc, tol2, ntol2;
   status_type                     status_in;
   logic signed [RW-1:0]           two_sd, t_r, rad0_in, rad1_in;
   logic                           root_case, four_case;

   function automatic logic below(input logic signed [TW-1:0] x,
                                  input logic [TOL_WIDTH-1:0] lim);
      logic [TW-1:0] m;
      m = x[TW-1] ? TW'(-x) : TW'(x);
      return m < TW'(lim);
   endfunction

   function automatic logic positive(input logic signed [RW-1:0] x);
      return !x[RW-1] && (x != '0);
   endfunction

   always_comb begin
      zero_in  = below(TW'(p0_ff), tol) && below(TW'(q0_ff), tol) &&
                 below(TW'(r0_ff), tol) && below(TW'(s0_ff), tol);
      ident_in = below(TW'(p0_ff) - ONE_T, tol) && below(TW'(q0_ff), tol) &&
                 below(TW'(r0_ff), tol) && below(TW'(s0_ff) - ONE_T, tol);
   end

   always_comb begin
      tol2  = $signed(DSW'(tol) << FRAC_BITS);
      ntol2 = -tol2;
      disc  = DSW'(tt2_ff) - (DSW'(det2_ff) <<< 2);
      if (disc < ntol2) status_in = ST_COMPLEX;
      else if (zero2_ff) status_in = ST_ZERO;
      else if (ident2_ff) status_in = ST_IDENT;
      else if (DSW'(det2_ff) < ntol2) status_in = ST_NEGDET;
      else if (disc > ntol2 && disc < tol2) status_in = ST_TWO;
      else status_in = ST_FOUR;
   end

   // last stage: radicands from trace and sqrt of det
   always_comb begin
      two_sd    = $signed({2'b00, sroot[DATA_WIDTH-1:0], 1'b0});
      t_r       = RW'(sd_ff[SK-1].t);
      four_case = sd_ff[SK-1].status == ST_FOUR;
      root_case = four_case || sd_ff[SK-1].status == ST_TWO;
      rad0_in   = four_case ? t_r + two_sd : t_r <<< 1;
      rad1_in   = t_r - two_sd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FL-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= m00;
         q0_ff <= m01;
         r0_ff <= m10;
         s0_ff <= m11;

         t1_ff     <= TW'(p0_ff) + TW'(s0_ff);
         d1_ff     <= TW'(p0_ff) - TW'(s0_ff);
         ps1_ff    <= p0_ff * s0_ff;
         qr1_ff    <= q0_ff * r0_ff;
         q1_ff     <= q0_ff;
         r1_ff     <= r0_ff;
         zero1_ff  <= zero_in;
         ident1_ff <= ident_in;

         t2_ff     <= t1_ff;
         d2_ff     <= d1_ff;
         q2_ff     <= q1_ff;
         r2_ff     <= r1_ff;
         tt2_ff    <= t1_ff * t1_ff;
         det2_ff   <= DDW'(ps1_ff) - DDW'(qr1_ff);
         zero2_ff  <= zero1_ff;
         ident2_ff <= ident1_ff;

         s3_ff.status <= status_in;
         s3_ff.t      <= t2_ff;
         s3_ff.d      <= d2_ff;
         s3_ff.q      <= q2_ff;
         s3_ff.r      <= r2_ff;
         sqd3_ff      <= det2_ff[DDW-1] ? '0 : (2*SK)'(det2_ff[2*DATA_WIDTH-1:0]);

         sd_ff[0] <= s3_ff;
         for (int i = 1; i < SK; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end

         o_ff.status <= sd_ff[SK-1].status;
         o_ff.ok0    <= root_case && positive(rad0_in);
         o_ff.ok1    <= four_case && positive(rad1_in);
         o_ff.rad0   <= rad0_in;
         o_ff.rad1   <= rad1_in;
         o_ff.d      <= sd_ff[SK-1].d;
         o_ff.q      <= sd_ff[SK-1].q;
         o_ff.r      <= sd_ff[SK-1].r;
      end
   end

   msr_isqrt u_sqrt_det (
      .clock (clock),
      .en    (en),
      .rad   (sqd3_ff),
      .root  (sroot)
   );

   assign out_valid = vld_ff[FL-1];
   assign out_word  = o_ff;

endmodule

/* src/msr_root.sv */
module msr_root (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  msr_pkg::job_type      in_word,
   output logic                  out_valid,
   output msr_pkg::root_res_type out_word
);
   import msr_pkg::*;

   localparam int RL = SK + NMW + 3;

   logic [RL-1:0]        vld_ff;
   job_type              j_ff;
   job_type              sq_ff [SK];
   logic [2*SK-1:0]      u_rad;
   logic [SK-1:0]        u_root;
   logic [UW-1:0]        u;
   logic signed [RW:0]   a0, a3, qx, rx;
   logic [NMW-1:0]       n0_ff, n1_ff, n2_ff, n3_ff;
   logic [DVW-1:0]       dn1_ff, dn2_ff;
   meta_type             nm_ff;
   meta_type             dv_ff [NMW];
   logic [NMW-1:0]       q0, q1, q2, q3;
   root_res_type         o_ff;

   function automatic logic [RW-1:0] absw(input logic signed [RW:0] x);
      logic [RW:0] m;
      m = x[RW] ? (RW+1)'(-x) : (RW+1)'(x);
      return m[RW-1:0];
   endfunction

   function automatic logic signed [EW-1:0] apply(input logic [NMW-1:0] m, input logic n);
      logic signed [EW-1:0] v;
      v = $signed({1'b0, m});
      return n ? -v : v;
   endfunction

   assign u_rad = (2*SK)'(j_ff.rad[RW-2:0]) << FRAC_BITS;
   assign u     = u_root[UW-1:0];

   always_comb begin
      a0 = (RW+1)'(sq_ff[SK-1].rad) + (RW+1)'(sq_ff[SK-1].d);
      a3 = (RW+1)'(sq_ff[SK-1].rad) - (RW+1)'(sq_ff[SK-1].d);
      qx = (RW+1)'(sq_ff[SK-1].q);
      rx = (RW+1)'(sq_ff[SK-1].r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RL-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         j_ff <= in_word;

         sq_ff[0] <= j_ff;
         for (int i = 1; i < SK; i++) begin
            sq_ff[i] <= sq_ff[i-1];
         end

         n0_ff        <= NMW'(absw(a0)) << FRAC_BITS;
         n1_ff        <= NMW'(absw(qx)) << FRAC_BITS;
         n2_ff        <= NMW'(absw(rx)) << FRAC_BITS;
         n3_ff        <= NMW'(absw(a3)) << FRAC_BITS;
         dn2_ff       <= {u, 1'b0};
         dn1_ff       <= {1'b0, u};
         nm_ff.status <= sq_ff[SK-1].status;
         nm_ff.root   <= sq_ff[SK-1].root;
         nm_ff.last   <= sq_ff[SK-1].last;
         nm_ff.num    <= sq_ff[SK-1].num;
         nm_ff.neg    <= {a3[RW], rx[RW], qx[RW], a0[RW]};

         dv_ff[0] <= nm_ff;
         for (int i = 1; i < NMW; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end

         o_ff.status <= dv_ff[NMW-1].status;
         o_ff.root   <= dv_ff[NMW-1].root;
         o_ff.last   <= dv_ff[NMW-1].last;
         o_ff.num    <= dv_ff[NMW-1].num;
         o_ff.e0     <= apply(q0, dv_ff[NMW-1].neg[0]);
         o_ff.e1     <= apply(q1, dv_ff[NMW-1].neg[1]);
         o_ff.e2     <= apply(q2, dv_ff[NMW-1].neg[2]);
         o_ff.e3     <= apply(q3, dv_ff[NMW-1].neg[3]);
      end
   end

   msr_isqrt u_sqrt_rad (
      .clock (clock),
      .en    (en),
      .rad   (u_rad),
      .root  (u_root)
   );

   msr_div u_div0 (.clock(clock), .en(en), .num(n0_ff), .den(dn2_ff), .quo(q0));
   msr_div u_div1 (.clock(clock), .en(en), .num(n1_ff), .den(dn1_ff), .quo(q1));
   msr_div u_div2 (.clock(clock), .en(en), .num(n2_ff), .den(dn1_ff), .quo(q2));
   msr_div u_div3 (.clock(clock), .en(en), .num(n3_ff), .den(dn2_ff), .quo(q3));

   assign out_valid = vld_ff[RL-1];
   assign out_word  = o_ff;

endmodule

/* tb/tb_matrix_square_root_2x2.sv */
`timescale 1ns / 1ps

module tb_matrix_square_root_2x2;
   import msr_pkg::*;

   localparam int ONE_Q = 1 << FRAC_BITS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 74;

   class msr_scoreboard;
      logic [TOL_WIDTH-1:0] tol;
      result_type pending[$];
      int errors;

      function new();
         tol = 1;
         errors = 0;
      endfunction

      function logic [127:0] isqrt(logic [127:0] n);
         logic [127:0] x, res, b_;
         x = n;
         res = 0;
         b_ = 128'd1 << 126;
         while (b_ > x && b_ != 0) b_ = b_ >> 2;
         while (b_ != 0) begin
            if (x >= res + b_) begin
               x = x - (res + b_);
               res = (res >> 1) + b_;
            end else begin
               res = res >> 1;
            end
            b_ = b_ >> 2;
         end
         return res;
      endfunction

      function logic [DATA_WIDTH-1:0] clamp(logic signed [127:0] v, inout bit clip);
         logic signed [127:0] hi_lim, lo_lim;
         hi_lim = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
         lo_lim = -(128'sd1 <<< (DATA_WIDTH - 1));
         if (v > hi_lim) begin
            clip = 1;
            return hi_lim[DATA_WIDTH-1:0];
         end
         if (v < lo_lim) begin
            clip = 1;
            return lo_lim[DATA_WIDTH-1:0];
         end
         return v[DATA_WIDTH-1:0];
      endfunction

      function bit tiny(longint x);
         longint m;
         m = (x < 0) ? -x : x;
         return m < longint'(tol);
      endfunction

      function void push_root(status_type st, int num, logic signed [127:0] e0,
                              logic signed [127:0] e1, logic signed [127:0] e2,
                              logic signed [127:0] e3);
         result_type w;
         bit clip;
         clip = 0;
         w.status = st;
         w.root_number = num[1:0];
         w.r00 = clamp(e0, clip);
         w.r01 = clamp(e1, clip);
         w.r10 = clamp(e2, clip);
         w.r11 = clamp(e3, clip);
         w.saturated = clip;
         w.last = 0;
         pending.push_back(w);
      endfunction

      function void note_matrix(logic signed [DATA_WIDTH-1:0] a, logic signed [DATA_WIDTH-1:0] b,
                                logic signed [DATA_WIDTH-1:0] c, logic signed [DATA_WIDTH-1:0] e);
         longint p, q, r, s, t, d, sd;
         longint rad[2];
         logic signed [127:0] bp, bq, br, bs, bt, det, disc, tol2, u, e0, e1, e2, e3;
         status_type st;
         int nrad, cnt, i;
         bit rooted;
         result_type w;
         p = a; q = b; r = c; s = e;
         t = p + s;
         d = p - s;
         bp = p; bq = q; br = r; bs = s; bt = t;
         det = bp * bs - bq * br;
         disc = bt * bt - 4 * det;
         tol2 = 128'(tol) << FRAC_BITS;
         rooted = 0;
         cnt = 0;
         nrad = 0;
         if (disc < -tol2) st = ST_COMPLEX;
         else if (tiny(p) && tiny(q) && tiny(r) && tiny(s)) st = ST_ZERO;
         else if (tiny(p - ONE_Q) && tiny(q) && tiny(r) && tiny(s - ONE_Q)) st = ST_IDENT;
         else if (det < -tol2) st = ST_NEGDET;
         else begin
            rooted = 1;
            if (disc > -tol2 && disc < tol2) begin
               st = ST_TWO;
               nrad = 1;
               rad[0] = 2 * t;
               rad[1] = 0;
            end else begin
               sd = (det < 0) ? 0 : longint'(isqrt(det));
               st = ST_FOUR;
               nrad = 2;
               rad[0] = t + 2 * sd;
               rad[1] = t - 2 * sd;
            end
         end
         if (rooted) begin
            for (i = 0; i < nrad; i++) begin
               if (rad[i] > 0) begin
                  u = isqrt(128'(rad[i]) << FRAC_BITS);
                  e0 = (128'(rad[i] + d) <<< FRAC_BITS) / (2 * u);
                  e1 = (128'(q) <<< FRAC_BITS) / u;
                  e2 = (128'(r) <<< FRAC_BITS) / u;
                  e3 = (128'(rad[i] - d) <<< FRAC_BITS) / (2 * u);
                  push_root(st, cnt, e0, e1, e2, e3);
                  push_root(st, cnt + 1, -e0, -e1, -e2, -e3);
                  cnt += 2;
               end
            end
            if (cnt == 0) st = ST_UNDEF;
         end
         if (cnt == 0) begin
            w = '0;
            w.status = st;
            pending.push_back(w);
         end
         pending[pending.size() - 1].last = 1;
      endfunction

      function void cmp(string fname, longint exp_v, longint got_v);
         if (exp_v != got_v) begin
            errors++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, fname, exp_v, got_v);
         end
      endfunction

      function void check(result_type got);
         result_type w;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected result word status %0d", $time, got.status);
            return;
         end
         w = pending.pop_front();
         cmp("status", w.status, got.status);
         cmp("root_number", w.root_number, got.root_number);
         cmp("r00", w.r00, got.r00);
         cmp("r01", w.r01, got.r01);
         cmp("r10", w.r10, got.r10);
         cmp("r11", w.r11, got.r11);
         cmp("saturated", w.saturated, got.saturated);
         cmp("last", w.last, got.last);
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready;
   logic signed [DATA_WIDTH-1:0] req_m00, req_m01, req_m10, req_m11;
   logic rsp_valid, rsp_ready;
   logic [2:0] rsp_status;
   logic [1:0] rsp_root_number;
   logic signed [DATA_WIDTH-1:0] rsp_r00, rsp_r01, rsp_r10, rsp_r11;
   logic rsp_saturated, rsp_last;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_WIDTH-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   msr_scoreboard sb = new();
   bit quiet = 0;
   int cycles = 0;

   matrix_square_root_2x2 u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = status_type'(rsp_status);
         got.root_number = rsp_root_number;
         got.r00 = rsp_r00;
         got.r01 = rsp_r01;
         got.r10 = rsp_r10;
         got.r11 = rsp_r11;
         got.saturated = rsp_saturated;
         got.last = rsp_last;
         sb.check(got);
      end
   end

   initial begin
      rsp_ready <= 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send_matrix(int a, int b, int c, int e);
      req_valid <= 1;
      req_m00 <= a;
      req_m01 <= b;
      req_m10 <= c;
      req_m11 <= e;
      do @(posedge clock); while (!req_ready);
      sb.note_matrix(a, b, c, e);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_WIDTH-1:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= ADDR_WIDTH'(REG_TOLERANCE * 4);
      csr_pwdata <= CSR_WIDTH'(value);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      sb.tol = value;
   endtask

   function automatic int srnd(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   task automatic send_random();
      int kind, x, lim;
      kind = $urandom_range(0, 9);
      lim = 1 << $urandom_range(8, 22);
      case (kind)
         0, 1, 2: begin
            send_matrix($urandom, $urandom, $urandom, $urandom);
         end
         3, 4, 5: begin
            send_matrix($urandom_range(0, lim), srnd(lim / 4), srnd(lim / 4),
                        $urandom_range(0, lim));
         end
         6: begin
            x = srnd(lim);
            send_matrix(x, srnd(lim), 0, x);
         end
         7: begin
            x = ($urandom_range(0, 1) != 0) ? ONE_Q : 0;
            send_matrix(x + srnd(4), srnd(4), srnd(4), x + srnd(4));
         end
         8: begin
            send_matrix(srnd(lim), srnd(lim), srnd(lim), srnd(lim));
         end
         default: begin
            send_matrix($urandom_range(32'h40000000, 32'h7fffffff), srnd(1 << 30),
                        srnd(8), $urandom_range(0, 16));
         end
      endcase
   endtask

   initial begin
      int ph, k;
      reset <= 1;
      req_valid <= 0;
      req_m00 <= 0;
      req_m01 <= 0;
      req_m10 <= 0;
      req_m11 <= 0;
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      csr_paddr <= 0;
      csr_pwdata <= 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero, identity, complex, negative det, two and four roots
      send_matrix(0, 0, 0, 0);
      send_matrix(ONE_Q, 0, 0, ONE_Q);
      send_matrix(0, -ONE_Q, ONE_Q, 0);
      send_matrix(ONE_Q, 0, 0, -ONE_Q);
      send_matrix(ONE_Q, ONE_Q, 0, ONE_Q);
      send_matrix(4 * ONE_Q, 0, 0, 9 * ONE_Q);
      send_matrix(5 * ONE_Q, 2 * ONE_Q, ONE_Q, 3 * ONE_Q);
      // no positive radicand
      send_matrix(-ONE_Q, 0, 0, -4 * ONE_Q);
      send_matrix(-ONE_Q, ONE_Q, 0, -ONE_Q);
      // slightly negative det taken as zero
      send_matrix(ONE_Q, 1, 1, 0);
      // extremes
      send_matrix(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_matrix(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_matrix(32'h7fffffff, 0, 0, 32'h7fffffff);
      send_matrix(32'h7fffffff, 32'h80000000, 0, 1);
      send_matrix(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_matrix(1, 0, 0, 1);
      send_matrix(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_matrix(1, 32'h7fffffff, 0, 1);
      send_matrix(ONE_Q, 32'h7fffffff, 32'h7fffffff, ONE_Q);
      send_matrix(-1, 0, 0, -1);

      for (ph = 0; ph < 5; ph++) begin
         drain();
         case (ph)
            0: write_tolerance(0);
            1: write_tolerance(16'hffff);
            2: write_tolerance($urandom_range(0, 65535));
            3: write_tolerance($urandom_range(0, 64));
            default: write_tolerance(1);
         endcase
         if (ph == 4) quiet = 1;
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (ph == 2 && k == RANDOM_PER_PHASE / 2) begin
               req_valid <= 0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
            send_random();
         end
      end

      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
src/msr_pkg.sv
src/msr_isqrt.sv
src/msr_div.sv
src/msr_front.sv
src/msr_root.sv
src/matrix_square_root_2x2.sv
tb/tb_matrix_square_root_2x2.sv
